@@ sv/jac_pkg.sv @@
// Shared constants, types and codes of the joystick axis conditioner.
package jac_pkg;

	localparam int AVG_COUNT    = 20;
	localparam int SAMPLE_W     = 8;
	localparam int SUM_W        = 13;
	localparam int CNT_W        = $clog2(AVG_COUNT + 1);
	localparam int AVG_SHIFT    = SUM_W + 5;
	localparam int RECIP_W      = AVG_SHIFT + 1;
	localparam int PROD_W       = SUM_W + RECIP_W;
	localparam int MAG_W        = 8;
	localparam int OFF_W        = MAG_W + 1;
	localparam int GAIN_W       = 9;
	localparam int SCALE_W      = MAG_W + GAIN_W;
	localparam int FRAC_W       = 8;
	localparam int POS_W        = 10;
	localparam int DIR_W        = 3;
	localparam int NUM_AXES     = 2;
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_W      = $clog2(Q_DEPTH);
	localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 9;

	localparam logic [RECIP_W-1:0] AVG_RECIP =
		RECIP_W'(((1 << AVG_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);

	localparam logic [MAG_W-1:0]  CENTER_X_RST   = 8'd160;
	localparam logic [MAG_W-1:0]  CENTER_Y_RST   = 8'd159;
	localparam logic [MAG_W-1:0]  DEAD_ZONE_RST  = 8'd20;
	localparam logic [GAIN_W-1:0] GAIN_X_POS_RST = 9'd271;
	localparam logic [GAIN_W-1:0] GAIN_X_NEG_RST = 9'd161;
	localparam logic [GAIN_W-1:0] GAIN_Y_POS_RST = 9'd269;
	localparam logic [GAIN_W-1:0] GAIN_Y_NEG_RST = 9'd164;

	typedef enum logic [DIR_W-1:0] {
		DIR_NEUTRAL = 3'd0,
		DIR_RIGHT   = 3'd1,
		DIR_LEFT    = 3'd2,
		DIR_UP      = 3'd3,
		DIR_DOWN    = 3'd4
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X   = 3'd0,
		CFG_CENTER_Y   = 3'd1,
		CFG_DEAD_ZONE  = 3'd2,
		CFG_GAIN_X_POS = 3'd3,
		CFG_GAIN_X_NEG = 3'd4,
		CFG_GAIN_Y_POS = 3'd5,
		CFG_GAIN_Y_NEG = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [MAG_W-1:0]  center_x;
		logic [MAG_W-1:0]  center_y;
		logic [MAG_W-1:0]  dead_zone;
		logic [GAIN_W-1:0] gain_x_pos;
		logic [GAIN_W-1:0] gain_x_neg;
		logic [GAIN_W-1:0] gain_y_pos;
		logic [GAIN_W-1:0] gain_y_neg;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] x_sum;
		logic [SUM_W-1:0] y_sum;
	} sums_t;

endpackage

@@ sv/jac_in_if.sv @@
// Sample channel: one X/Y converter sample pair per word.
interface jac_in_if
	import jac_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] x_sample;
	logic [SAMPLE_W-1:0] y_sample;

	modport source (output valid, output x_sample, output y_sample, input ready);
	modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

@@ sv/jac_out_if.sv @@
// Result channel: conditioned X/Y positions and direction code per word.
interface jac_out_if
	import jac_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] x_position;
	logic signed [POS_W-1:0] y_position;
	logic [DIR_W-1:0]        direction;

	modport source (output valid, output x_position, output y_position,
		output direction, input ready);
	modport sink (input valid, input x_position, input y_position,
		input direction, output ready);
endinterface

@@ sv/jac_fifo.sv @@
// Short queue of completed sample sums between the front and the back.
module jac_fifo
	import jac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  sums_t push_data,
	output logic  full,
	input  logic  pop,
	output sums_t pop_data,
	output logic  not_empty
);

	sums_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/jac_front.sv @@
// Front end: accepts sample pairs and accumulates them into per-axis sums.
module jac_front
	import jac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	jac_in_if.sink sample,
	input  logic  q_full,
	output logic  push,
	output sums_t push_data
);

	logic [SUM_W-1:0] x_sum_q;
	logic [SUM_W-1:0] y_sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] x_next;
	logic [SUM_W-1:0] y_next;
	logic             acc;
	logic             last;

	assign sample.ready = !q_full;
	assign acc          = sample.valid && sample.ready;
	assign last         = (cnt_q == CNT_W'(AVG_COUNT - 1));
	assign x_next       = x_sum_q + SUM_W'(sample.x_sample);
	assign y_next       = y_sum_q + SUM_W'(sample.y_sample);

	assign push            = acc && last;
	assign push_data.x_sum = x_next;
	assign push_data.y_sum = y_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			cnt_q   <= '0;
		end else if (acc) begin
			if (last) begin
				x_sum_q <= '0;
				y_sum_q <= '0;
				cnt_q   <= '0;
			end else begin
				x_sum_q <= x_next;
				y_sum_q <= y_next;
				cnt_q   <= cnt_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/jac_back.sv @@
// Back end: averaging, dead zone, gain scaling and direction, with output register.
module jac_back
	import jac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_vld,
	input  sums_t q_data,
	output logic  q_pop,
	jac_out_if.source result
);

	logic                    adv;
	logic                    out_vld_q;
	logic                    vld_s1;
	logic                    vld_s2;
	logic                    vld_s3;

	logic [SUM_W-1:0]        sum_in   [NUM_AXES];
	logic [MAG_W-1:0]        center   [NUM_AXES];
	logic [GAIN_W-1:0]       gain_pos [NUM_AXES];
	logic [GAIN_W-1:0]       gain_neg [NUM_AXES];

	logic [PROD_W-1:0]       prod_s1  [NUM_AXES];
	logic [MAG_W-1:0]        avg      [NUM_AXES];
	logic [OFF_W-1:0]        off      [NUM_AXES];
	logic [MAG_W-1:0]        mag      [NUM_AXES];

	logic [MAG_W-1:0]        mag_s2   [NUM_AXES];
	logic [GAIN_W-1:0]       gain_s2  [NUM_AXES];
	logic                    neg_s2   [NUM_AXES];
	logic                    dz_s2    [NUM_AXES];

	logic [SCALE_W-1:0]      prod_s3  [NUM_AXES];
	logic                    neg_s3   [NUM_AXES];

	logic [GAIN_W-1:0]       scaled   [NUM_AXES];
	logic signed [POS_W-1:0] pos      [NUM_AXES];
	logic                    y_pos_gt0;
	dir_t                    dir;

	logic signed [POS_W-1:0] x_pos_q;
	logic signed [POS_W-1:0] y_pos_q;
	dir_t                    dir_q;

	assign adv   = !out_vld_q || result.ready;
	assign q_pop = q_vld && adv;

	assign sum_in[0]   = q_data.x_sum;
	assign sum_in[1]   = q_data.y_sum;
	assign center[0]   = cfg.center_x;
	assign center[1]   = cfg.center_y;
	assign gain_pos[0] = cfg.gain_x_pos;
	assign gain_pos[1] = cfg.gain_y_pos;
	assign gain_neg[0] = cfg.gain_x_neg;
	assign gain_neg[1] = cfg.gain_y_neg;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			avg[a] = prod_s1[a][AVG_SHIFT +: MAG_W];
			off[a] = {1'b0, avg[a]} - {1'b0, center[a]};
			mag[a] = off[a][OFF_W-1] ? MAG_W'(-off[a]) : off[a][MAG_W-1:0];
		end
	end

	// Nine bits of scaled magnitude already cover the full +/-511 range.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			scaled[a] = prod_s3[a][FRAC_W +: GAIN_W];
			pos[a]    = neg_s3[a] ? -$signed({1'b0, scaled[a]}) : $signed({1'b0, scaled[a]});
		end
		y_pos_gt0 = !neg_s3[1] && (scaled[1] != '0);
		if ((scaled[0] == '0) && (scaled[1] == '0)) begin
			dir = DIR_NEUTRAL;
		end else if (scaled[0] > scaled[1]) begin
			dir = neg_s3[0] ? DIR_LEFT : DIR_RIGHT;
		end else begin
			dir = y_pos_gt0 ? DIR_UP : DIR_DOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= q_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_s1[a] <= PROD_W'(sum_in[a]) * PROD_W'(AVG_RECIP);
				mag_s2[a]  <= mag[a];
				neg_s2[a]  <= off[a][OFF_W-1];
				gain_s2[a] <= off[a][OFF_W-1] ? gain_neg[a] : gain_pos[a];
				dz_s2[a]   <= (mag[a] < cfg.dead_zone);
				prod_s3[a] <= dz_s2[a] ? '0 : SCALE_W'(mag_s2[a]) * SCALE_W'(gain_s2[a]);
				neg_s3[a]  <= neg_s2[a];
			end
			x_pos_q <= pos[0];
			y_pos_q <= pos[1];
			dir_q   <= dir;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.x_position = x_pos_q;
	assign result.y_position = y_pos_q;
	assign result.direction  = dir_q;

endmodule

@@ sv/joystick_axis_conditioner.sv @@
// Top level of the joystick axis conditioner.
// The sample channel carries one 8-bit X and Y converter sample pair per word.
// Every AVG_COUNT accepted words produce one word on the result channel: the averaged,
// centered, dead-zoned and gain-scaled X and Y positions and a direction code.
// After the last contributing sample is accepted, its sums pass through the sum queue,
// the multiply pipeline of the back end and the output register to the result channel.
// Throughput is one sample word per cycle while the sum queue is not full.
// The configuration port writes one register per cycle at cfg_index; the user must
// write it only while no samples are in flight, which the block does not enforce.
// Reset clears the sums, the sample count, the queue and the pipeline, and loads
// the default center, dead zone and gain values.
// When the result receiver stalls, the back end holds its pipeline, the two-entry
// sum queue fills, and only then does sample.ready drop.
module joystick_axis_conditioner
	import jac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	jac_in_if.sink                sample,
	jac_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  push;
	sums_t push_data;
	logic  q_full;
	logic  q_pop;
	sums_t q_data;
	logic  q_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= CENTER_X_RST;
			cfg_q.center_y   <= CENTER_Y_RST;
			cfg_q.dead_zone  <= DEAD_ZONE_RST;
			cfg_q.gain_x_pos <= GAIN_X_POS_RST;
			cfg_q.gain_x_neg <= GAIN_X_NEG_RST;
			cfg_q.gain_y_pos <= GAIN_Y_POS_RST;
			cfg_q.gain_y_neg <= GAIN_Y_NEG_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:   cfg_q.center_x   <= cfg_data[MAG_W-1:0];
				CFG_CENTER_Y:   cfg_q.center_y   <= cfg_data[MAG_W-1:0];
				CFG_DEAD_ZONE:  cfg_q.dead_zone  <= cfg_data[MAG_W-1:0];
				CFG_GAIN_X_POS: cfg_q.gain_x_pos <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_X_NEG: cfg_q.gain_x_neg <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_Y_POS: cfg_q.gain_y_pos <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_Y_NEG: cfg_q.gain_y_neg <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	jac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	jac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_vld)
	);

	jac_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_vld  (q_vld),
		.q_data (q_data),
		.q_pop  (q_pop),
		.result (result)
	);

endmodule

@@ tb/joystick_axis_conditioner_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the joystick axis conditioner with a built-in scoreboard.
module joystick_axis_conditioner_tb;
	import jac_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 400_000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int NUM_REGS       = int'(CFG_GAIN_Y_NEG) + 1;
	localparam int POS_MAX        = (1 << (POS_W - 1)) - 1;
	localparam int MAX_PRINTS     = 60;
	localparam int RANDOM_PHASES  = 12;
	localparam int SETS_PER_PHASE = 4;
	localparam int HOLD_OFF       = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum int {
		REGS_RANDOM,
		REGS_MIN,
		REGS_MAX,
		REGS_NO_DEAD_ZONE
	} regs_kind_t;

	typedef struct {
		logic signed [POS_W-1:0] x_pos;
		logic signed [POS_W-1:0] y_pos;
		dir_t                    dir;
	} position_word_t;

	class jac_scoreboard;
		cfg_t           regs;
		int unsigned    x_acc;
		int unsigned    y_acc;
		int unsigned    n_pairs;
		position_word_t positions[$];
		int             errors;

		function new();
			regs = '{center_x: CENTER_X_RST, center_y: CENTER_Y_RST,
				dead_zone: DEAD_ZONE_RST, gain_x_pos: GAIN_X_POS_RST,
				gain_x_neg: GAIN_X_NEG_RST, gain_y_pos: GAIN_Y_POS_RST,
				gain_y_neg: GAIN_Y_NEG_RST};
			x_acc = 0;
			y_acc = 0;
			n_pairs = 0;
			errors = 0;
		endfunction

		function int pending();
			return positions.size();
		endfunction

		task report(input string msg);
			if (errors < MAX_PRINTS) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
			errors++;
		endtask

		function void write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_CENTER_X: regs.center_x = data[MAG_W-1:0];
				CFG_CENTER_Y: regs.center_y = data[MAG_W-1:0];
				CFG_DEAD_ZONE: regs.dead_zone = data[MAG_W-1:0];
				CFG_GAIN_X_POS: regs.gain_x_pos = data[GAIN_W-1:0];
				CFG_GAIN_X_NEG: regs.gain_x_neg = data[GAIN_W-1:0];
				CFG_GAIN_Y_POS: regs.gain_y_pos = data[GAIN_W-1:0];
				CFG_GAIN_Y_NEG: regs.gain_y_neg = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [POS_W-1:0] scale_axis(input int unsigned sum,
			input logic [MAG_W-1:0] center, input logic [GAIN_W-1:0] gain_pos,
			input logic [GAIN_W-1:0] gain_neg);
			int          offset;
			int unsigned mag;
			int unsigned scaled;
			int          signed_pos;
			offset = int'(sum / AVG_COUNT) - int'(center);
			mag = (offset < 0) ? -offset : offset;
			if (mag < regs.dead_zone) begin
				return '0;
			end
			scaled = (mag * ((offset < 0) ? gain_neg : gain_pos)) >> FRAC_W;
			if (scaled > POS_MAX) begin
				scaled = POS_MAX;
			end
			signed_pos = (offset < 0) ? -int'(scaled) : int'(scaled);
			return POS_W'(signed_pos);
		endfunction

		function void note_sample(input logic [SAMPLE_W-1:0] xs,
			input logic [SAMPLE_W-1:0] ys);
			position_word_t w;
			int             ax;
			int             ay;
			x_acc = (x_acc + xs) % (1 << SUM_W);
			y_acc = (y_acc + ys) % (1 << SUM_W);
			n_pairs++;
			if (n_pairs < AVG_COUNT) begin
				return;
			end
			w.x_pos = scale_axis(x_acc, regs.center_x, regs.gain_x_pos, regs.gain_x_neg);
			w.y_pos = scale_axis(y_acc, regs.center_y, regs.gain_y_pos, regs.gain_y_neg);
			x_acc = 0;
			y_acc = 0;
			n_pairs = 0;
			ax = (w.x_pos < 0) ? -int'(w.x_pos) : int'(w.x_pos);
			ay = (w.y_pos < 0) ? -int'(w.y_pos) : int'(w.y_pos);
			if (ax == 0 && ay == 0) begin
				w.dir = DIR_NEUTRAL;
			end else if (ax > ay) begin
				w.dir = (w.x_pos > 0) ? DIR_RIGHT : DIR_LEFT;
			end else begin
				w.dir = (w.y_pos > 0) ? DIR_UP : DIR_DOWN;
			end
			positions.push_back(w);
		endfunction

		task check_result(input logic signed [POS_W-1:0] xp,
			input logic signed [POS_W-1:0] yp, input logic [DIR_W-1:0] dir);
			position_word_t w;
			if (positions.size() == 0) begin
				report($sformatf("unexpected word x=%0d y=%0d dir=%0d", xp, yp, dir));
				return;
			end
			w = positions.pop_front();
			if (xp !== w.x_pos) begin
				report($sformatf("x_position got %0d want %0d", xp, w.x_pos));
			end
			if (yp !== w.y_pos) begin
				report($sformatf("y_position got %0d want %0d", yp, w.y_pos));
			end
			if (dir !== w.dir) begin
				report($sformatf("direction got %0d want %0d", dir, w.dir));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jac_in_if  sample_if ();
	jac_out_if result_if ();

	jac_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	joystick_axis_conditioner u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL joystick_axis_conditioner");
		$finish;
	end

	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
			@(negedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
				sb.check_result(result_if.x_position, result_if.y_position,
					result_if.direction);
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] xs,
		input logic [SAMPLE_W-1:0] ys);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
		sample_if.valid <= 1'b1;
		sample_if.x_sample <= xs;
		sample_if.y_sample <= ys;
		while (!taken) begin
			@(negedge clk);
			taken = (sample_if.ready === 1'b1);
			@(posedge clk);
		end
		sb.note_sample(xs, ys);
	endtask

	// One averaging window of words scattered around a target position.
	task automatic send_set(input int x_mid, input int y_mid, input int spread);
		int xs;
		int ys;
		for (int n = 0; n < AVG_COUNT; n++) begin
			xs = x_mid + int'($urandom_range(0, 2 * spread)) - spread;
			ys = y_mid + int'($urandom_range(0, 2 * spread)) - spread;
			xs = (xs < 0) ? 0 : ((xs > 255) ? 255 : xs);
			ys = (ys < 0) ? 0 : ((ys > 255) ? 255 : ys);
			send_sample(SAMPLE_W'(xs), SAMPLE_W'(ys));
		end
	endtask

	task automatic wait_drain();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [NUM_REGS]);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom_range(0, 511));
		for (int i = CFG_CENTER_X; i <= CFG_GAIN_Y_NEG; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			sb.write_reg(CFG_IDX_W'(i), vals[i]);
			@(posedge clk);
		end
		cfg_index <= CFG_NONE;
		cfg_data <= junk;
		sb.write_reg(CFG_NONE, junk);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] reg_vals [NUM_REGS];
		regs_kind_t kind;
		idle_mode_t mode;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_if.valid <= 1'b0;
		sample_if.x_sample <= '0;
		sample_if.y_sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-on settings: both rails, exact center, and both edges of the dead zone.
		send_set(0, 0, 0);
		send_set(255, 255, 0);
		send_set(int'(CENTER_X_RST), int'(CENTER_Y_RST), 0);
		send_set(int'(CENTER_X_RST) + int'(DEAD_ZONE_RST), int'(CENTER_Y_RST), 0);
		send_set(int'(CENTER_X_RST) + int'(DEAD_ZONE_RST) - 1, int'(CENTER_Y_RST), 0);
		send_set(int'(CENTER_X_RST) - int'(DEAD_ZONE_RST), int'(CENTER_Y_RST), 0);
		send_set(int'(CENTER_X_RST), int'(CENTER_Y_RST) - int'(DEAD_ZONE_RST) + 1, 0);
		for (int n = 0; n < AVG_COUNT; n++) begin
			send_sample((n % 2 == 1) ? 8'd255 : 8'd0, (n % 2 == 1) ? 8'd0 : 8'd255);
		end
		wait_drain();

		// Unit gains with no dead zone, so equal deflections expose the tie rule.
		reg_vals[CFG_CENTER_X] = 9'd128;
		reg_vals[CFG_CENTER_Y] = 9'd128;
		reg_vals[CFG_DEAD_ZONE] = 9'd0;
		reg_vals[CFG_GAIN_X_POS] = 9'd256;
		reg_vals[CFG_GAIN_X_NEG] = 9'd256;
		reg_vals[CFG_GAIN_Y_POS] = 9'd256;
		reg_vals[CFG_GAIN_Y_NEG] = 9'd256;
		program_regs(reg_vals);
		send_set(138, 118, 0);
		send_set(118, 138, 0);
		send_set(129, 128, 0);
		send_set(128, 128, 0);
		send_set(255, 0, 0);
		wait_drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			kind = regs_kind_t'(p % 4);
			mode = idle_mode_t'((p / 4 + p) % 4);
			for (int i = 0; i < NUM_REGS; i++) begin
				case (kind)
					REGS_MIN: reg_vals[i] = '0;
					REGS_MAX: reg_vals[i] = '1;
					default: reg_vals[i] = CFG_DATA_W'($urandom_range(0, 511));
				endcase
			end
			if (kind == REGS_NO_DEAD_ZONE) begin
				reg_vals[CFG_DEAD_ZONE] = '0;
			end else if (kind == REGS_RANDOM) begin
				reg_vals[CFG_DEAD_ZONE] = CFG_DATA_W'($urandom_range(0, 80)
					| ($urandom_range(0, 1) << MAG_W));
			end
			program_regs(reg_vals);
			case (mode)
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			if (p == 7) begin
				hold_cycles = HOLD_OFF;
			end
			for (int s = 0; s < SETS_PER_PHASE; s++) begin
				if (p == 9 && s == SETS_PER_PHASE / 2) begin
					wait_drain();
				end
				if ($urandom_range(0, 99) < 80) begin
					send_set($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 12));
				end else begin
					send_set(128, 128, 128);
				end
			end
			wait_drain();
		end

		if (sb.errors == 0) begin
			$display("PASS joystick_axis_conditioner");
		end else begin
			$display("FAIL joystick_axis_conditioner");
		end
		$finish;
	end

endmodule
